/* sv/learning_message_router_unit_macros.svh */
// Assertion macros for the learning message router.
// Included by learning_message_router_unit, which carries the concurrent checks; depends on nothing.
`ifndef LEARNING_MESSAGE_ROUTER_UNIT_MACROS_SVH
`define LEARNING_MESSAGE_ROUTER_UNIT_MACROS_SVH

`ifndef SYNTH
`define LMR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lmr check failed: same-cycle implication");
`define LMR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lmr check failed: next-cycle implication");
`else
`define LMR_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define LMR_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* sv/lmr_pkg.sv */
// Shared types, codes and helper functions of the learning message router.
// Used by lmr_resolve and learning_message_router_unit; depends on nothing.
package lmr_pkg;

  localparam int unsigned TableDepth = 128;
  localparam int unsigned IdxW       = 7;
  localparam int unsigned AddrW      = 8;
  localparam int unsigned ChW        = 3;
  localparam int unsigned EntW       = 4;
  localparam int unsigned MaskW      = 7;
  localparam int unsigned TypeW      = 4;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 7;

  localparam logic [EntW-1:0] EntryNoRoute = 4'hF;

  // Message type codes that the router reacts to.
  localparam logic [TypeW-1:0] MT_REQUEST_ADDR   = 4'd1;
  localparam logic [TypeW-1:0] MT_BROADCAST_ADDR = 4'd3;
  localparam logic [TypeW-1:0] MT_PING           = 4'd6;
  localparam logic [TypeW-1:0] MT_FIRST_HANDLED  = 4'd7;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_LOCAL_ADDR  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_CHAN_ENABLE = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_HANDLER_EN  = 2'd2;

  typedef enum logic [2:0] {
    ACT_DROP    = 3'd0,
    ACT_DELIVER = 3'd1,
    ACT_PONG    = 3'd2,
    ACT_FLOOD   = 3'd3,
    ACT_SUPPLY  = 3'd4,
    ACT_FORWARD = 3'd5
  } action_e;

  typedef struct packed {
    logic [ChW-1:0]   ing;
    logic [AddrW-1:0] src;
    logic [AddrW-1:0] dst;
    logic [TypeW-1:0] typ;
  } item_t;

  typedef struct packed {
    action_e          action;
    logic             route_valid;
    logic [ChW-1:0]   channel;
    logic [MaskW-1:0] mask;
    logic [AddrW-1:0] rsrc;
    logic [AddrW-1:0] rdst;
  } result_t;

  // An unset address (zero) and the all-ones address both mean 127.
  function automatic logic [IdxW-1:0] eff_local(input logic [IdxW-1:0] a);
    return (a == '0 || a == '1) ? '1 : a;
  endfunction

  // Address whose route the item needs: the source for a ping to this node,
  // the supplied address for an address request, otherwise the destination.
  function automatic logic [AddrW-1:0] lookup_addr(input item_t it,
                                                   input logic [IdxW-1:0] loc_addr,
                                                   input logic [AddrW-1:0] unk);
    logic [AddrW-1:0] res;
    res = it.dst;
    if (it.dst == {1'b0, loc_addr} && it.typ == MT_PING) begin
      res = it.src;
    end else if (it.dst == unk && it.typ == MT_REQUEST_ADDR) begin
      res = {1'b1, loc_addr};
    end
    return res;
  endfunction

endpackage

/* sv/learning_message_router_unit.sv */
// Top level of the learning message router: route table RAM, learning writes,
// result register. Depends on lmr_pkg, lmr_ram, lmr_resolve and the macro header.
//
//  channel   direction  handshake                    payload
//  config    in         cfg_we_i                     cfg_idx_i, cfg_wdata_i
//  item      in         in_valid_i / in_ready_o      ingress_channel_i .. msg_type_i
//  result    out        res_valid_o / res_ready_i    action_o .. reply_dest_o
//
// Each header passes a transfer cycle and a resolve state: in the transfer cycle the table is read and the
// source is learned; in the resolve state the result is resolved and an address supply
// writes its second entry. The single write port of the table RAM sets this split.
// Reset clears per-entry valid bits at once; an entry never written reads as no route.
// A full result register holds the resolve state until the result is taken, and no new
// header is taken before that state ends, so a new header waits until the last one has left.
`include "learning_message_router_unit_macros.svh"

module learning_message_router_unit #(
  parameter int unsigned CHANNELS       = 7,
  parameter int unsigned BROADCAST_ADDR = 255,
  parameter int unsigned UNKNOWN_ADDR   = 0
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lmr_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [lmr_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [lmr_pkg::ChW-1:0]        ingress_channel_i,
  input  logic [lmr_pkg::AddrW-1:0]      src_address_i,
  input  logic [lmr_pkg::AddrW-1:0]      dest_address_i,
  input  logic [lmr_pkg::TypeW-1:0]      msg_type_i,
  output logic                           res_valid_o,
  input  logic                           res_ready_i,
  output logic [2:0]                     action_o,
  output logic                           out_valid_o,
  output logic [lmr_pkg::ChW-1:0]        out_channel_o,
  output logic [lmr_pkg::MaskW-1:0]      flood_mask_o,
  output logic [lmr_pkg::AddrW-1:0]      reply_src_o,
  output logic [lmr_pkg::AddrW-1:0]      reply_dest_o
);
  import lmr_pkg::*;

  typedef enum logic {S_IDLE, S_RESOLVE} state_e;

  localparam logic [4:0]       ChanLim = 5'(CHANNELS);
  localparam logic [AddrW-1:0] Bcast   = AddrW'(BROADCAST_ADDR);
  localparam logic [AddrW-1:0] Unk     = AddrW'(UNKNOWN_ADDR);

  state_e           state_q;
  item_t            item_d, item_q;
  logic [AddrW-1:0] lk_addr_d, lk_addr_q;
  logic             src_learned_d, src_learned_q;
  result_t          res_d, res_q;
  logic             res_valid_q;

  logic [IdxW-1:0]  local_addr_q, loc_addr;
  logic [MaskW-1:0] chan_en_q;
  logic             handler_en_q;

  logic [TableDepth-1:0] vld_q;
  logic                  rd_hit_q;
  logic                  accept, done, learn_local;
  logic                  we;
  logic [IdxW-1:0]       waddr;
  logic [EntW-1:0]       wdata, rd_entry;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_addr_q <= '1;
      chan_en_q    <= '0;
      handler_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LOCAL_ADDR:  local_addr_q <= cfg_wdata_i[IdxW-1:0];
        CFG_CHAN_ENABLE: chan_en_q    <= cfg_wdata_i[MaskW-1:0];
        CFG_HANDLER_EN:  handler_en_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign loc_addr   = eff_local(local_addr_q);
  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign done       = (state_q == S_RESOLVE) && (!res_valid_q || res_ready_i);

  always_comb begin
    item_d.ing    = ingress_channel_i;
    item_d.src    = src_address_i;
    item_d.dst    = dest_address_i;
    item_d.typ    = msg_type_i;
    lk_addr_d     = lookup_addr(item_d, loc_addr, Unk);
    src_learned_d = src_address_i != Unk && src_address_i != Bcast &&
                    ({2'b00, ingress_channel_i} < ChanLim);
  end

  // One write port: the source learn in the transfer cycle, the supplied
  // address learn when the item leaves the resolve cycle.
  always_comb begin
    if (accept) begin
      we    = src_learned_d;
      waddr = src_address_i[IdxW-1:0];
      wdata = {1'b0, ingress_channel_i};
    end else begin
      we    = done && learn_local;
      waddr = loc_addr;
      wdata = {1'b0, item_q.ing};
    end
  end

  lmr_ram #(
    .WIDTH (EntW),
    .DEPTH (TableDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (accept),
    .raddr_i (lk_addr_d[IdxW-1:0]),
    .rdata_o (rd_entry)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_hit_q <= 1'b0;
    end else begin
      if (we) begin
        vld_q[waddr] <= 1'b1;
      end
      if (accept) begin
        rd_hit_q <= vld_q[lk_addr_d[IdxW-1:0]];
      end
    end
  end

  lmr_resolve #(
    .CHANNELS       (CHANNELS),
    .BROADCAST_ADDR (BROADCAST_ADDR),
    .UNKNOWN_ADDR   (UNKNOWN_ADDR)
  ) u_resolve (
    .item_i        (item_q),
    .lk_addr_i     (lk_addr_q),
    .src_learned_i (src_learned_q),
    .rd_entry_i    (rd_entry),
    .rd_hit_i      (rd_hit_q),
    .loc_addr_i    (loc_addr),
    .chan_en_i     (chan_en_q),
    .handler_en_i  (handler_en_q),
    .res_o         (res_d),
    .learn_local_o (learn_local)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      item_q        <= '0;
      lk_addr_q     <= '0;
      src_learned_q <= 1'b0;
      res_q         <= '0;
      res_valid_q   <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q       <= S_RESOLVE;
            item_q        <= item_d;
            lk_addr_q     <= lk_addr_d;
            src_learned_q <= src_learned_d;
          end
        end
        S_RESOLVE: begin
          if (done) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      if (done) begin
        res_q       <= res_d;
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  assign res_valid_o   = res_valid_q;
  assign action_o      = res_q.action;
  assign out_valid_o   = res_q.route_valid;
  assign out_channel_o = res_q.channel;
  assign flood_mask_o  = res_q.mask;
  assign reply_src_o   = res_q.rsrc;
  assign reply_dest_o  = res_q.rdst;

  `LMR_ASSERT_NXT(a_accept_blocks, clk_i, rst_ni, accept, !in_ready_o && state_q == S_RESOLVE)
  `LMR_ASSERT_NXT(a_resolve_holds, clk_i, rst_ni, state_q == S_RESOLVE && res_valid_q && !res_ready_i, state_q == S_RESOLVE)
  `LMR_ASSERT_IMP(a_route_action, clk_i, rst_ni, res_valid_o && out_valid_o, action_o == ACT_PONG || action_o == ACT_SUPPLY || action_o == ACT_FORWARD)
  `LMR_ASSERT_IMP(a_mask_only_flood, clk_i, rst_ni, res_valid_o && action_o != ACT_FLOOD, flood_mask_o == '0)
  `LMR_ASSERT_IMP(a_route_enabled, clk_i, rst_ni, res_valid_o && out_valid_o, |(chan_en_q & (MaskW'(1) << out_channel_o)))

endmodule

/* sv/lmr_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Read during write to the same address returns the old data; no dependencies.
module lmr_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/lmr_resolve.sv */
// Decision logic of the router: picks the action and builds the result from
// the held item and the table read. Depends on lmr_pkg.
module lmr_resolve #(
  parameter int unsigned CHANNELS       = 7,
  parameter int unsigned BROADCAST_ADDR = 255,
  parameter int unsigned UNKNOWN_ADDR   = 0
) (
  input  lmr_pkg::item_t                  item_i,
  input  logic [lmr_pkg::AddrW-1:0]       lk_addr_i,
  input  logic                            src_learned_i,
  input  logic [lmr_pkg::EntW-1:0]        rd_entry_i,
  input  logic                            rd_hit_i,
  input  logic [lmr_pkg::IdxW-1:0]        loc_addr_i,
  input  logic [lmr_pkg::MaskW-1:0]       chan_en_i,
  input  logic                            handler_en_i,
  output lmr_pkg::result_t                res_o,
  output logic                            learn_local_o
);
  import lmr_pkg::*;

  localparam logic [4:0]       ChanLim = 5'(CHANNELS);
  localparam logic [AddrW-1:0] Bcast   = AddrW'(BROADCAST_ADDR);
  localparam logic [AddrW-1:0] Unk     = AddrW'(UNKNOWN_ADDR);

  logic [AddrW-1:0] loc8, pkt;
  logic             ing_ok, is_local, is_bc, is_unk, supply, route_ok;
  logic [EntW-1:0]  entry;
  logic [MaskW:0]   chan_en_x;
  logic [MaskW-1:0] flood;

  always_comb begin
    loc8      = {1'b0, loc_addr_i};
    pkt       = {1'b1, loc_addr_i};
    ing_ok    = {2'b00, item_i.ing} < ChanLim;
    is_local  = item_i.dst == loc8;
    is_bc     = !is_local && item_i.dst == Bcast;
    is_unk    = !is_local && !is_bc && item_i.dst == Unk;
    supply    = is_unk && item_i.typ == MT_REQUEST_ADDR;
    learn_local_o = supply && pkt != Bcast && ing_ok;

    // The table write of this item's learning is not yet visible in the read
    // data, so the ingress channel is forwarded where it applies.
    if (learn_local_o) begin
      entry = {1'b0, item_i.ing};
    end else if (src_learned_i && item_i.src[IdxW-1:0] == lk_addr_i[IdxW-1:0]) begin
      entry = {1'b0, item_i.ing};
    end else if (rd_hit_i) begin
      entry = rd_entry_i;
    end else begin
      entry = EntryNoRoute;
    end

    chan_en_x = {1'b0, chan_en_i};
    route_ok  = !(lk_addr_i == loc8 || lk_addr_i == Bcast) &&
                ({1'b0, entry} < ChanLim) && (entry < 4'd7) &&
                chan_en_x[entry[2:0]];

    if (ing_ok && item_i.ing != 3'd7) begin
      flood = chan_en_i & ~(MaskW'(1) << item_i.ing);
    end else begin
      flood = chan_en_i;
    end

    res_o = '0;
    if (is_local) begin
      if (item_i.typ == MT_PING) begin
        res_o.action      = ACT_PONG;
        res_o.rsrc        = item_i.dst;
        res_o.rdst        = item_i.src;
        res_o.route_valid = route_ok;
      end else if (item_i.typ >= MT_FIRST_HANDLED && handler_en_i) begin
        res_o.action = ACT_DELIVER;
        res_o.rsrc   = item_i.src;
        res_o.rdst   = item_i.dst;
      end
    end else if (is_bc) begin
      if (item_i.typ == MT_BROADCAST_ADDR) begin
        res_o.action = ACT_FLOOD;
        res_o.mask   = flood;
        res_o.rsrc   = item_i.src;
        res_o.rdst   = Bcast;
      end
    end else if (is_unk) begin
      if (supply) begin
        res_o.action      = ACT_SUPPLY;
        res_o.rsrc        = loc8;
        res_o.rdst        = pkt;
        res_o.route_valid = route_ok;
      end
    end else begin
      res_o.action      = ACT_FORWARD;
      res_o.rsrc        = item_i.src;
      res_o.rdst        = item_i.dst;
      res_o.route_valid = route_ok;
    end
    res_o.channel = res_o.route_valid ? entry[ChW-1:0] : '0;
  end

endmodule
